>>> src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands shared by ipb_fifo and ipb_back.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Condition must never be true outside reset.
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);

`endif

>>> src/ipb_pkg.sv
// ----------------------------------------------------------------------------
// ipb_pkg
// Shared types and constants of the pixel binner.
// ----------------------------------------------------------------------------
package ipb_pkg;

  localparam int MAX_ROW_WIDTH = 4096;
  localparam int MAX_ROWS      = 4096;
  localparam int MAX_BIN       = 64;

  localparam int COL_W  = 12;   // bin column / pixel column index
  localparam int ROW_W  = 12;   // bin row / pixel row index
  localparam int PIX_W  = 32;   // decoded pixel, signed
  localparam int SUM_W  = 44;   // exact bin sum, signed
  localparam int DATA_W = 13;   // widest configuration register

  // Configuration register indexes
  localparam logic [2:0] REG_BIN_X      = 3'd0;
  localparam logic [2:0] REG_BIN_Y      = 3'd1;
  localparam logic [2:0] REG_ROW_WIDTH  = 3'd2;
  localparam logic [2:0] REG_TOTAL_ROWS = 3'd3;
  localparam logic [2:0] REG_FORMAT     = 3'd4;

  // Pixel word formats
  typedef enum logic [1:0] {
    FMT_I32 = 2'd0,
    FMT_U16 = 2'd1,
    FMT_I16 = 2'd2,
    FMT_U8  = 2'd3
  } ipb_fmt_e;

  // One classified pixel, front to back
  typedef struct packed {
    logic signed [PIX_W-1:0] pix;
    logic                    seg_first;  // first pixel of bin within this row
    logic                    seg_end;    // last pixel of bin within this row
    logic                    row_first;  // first row of the bin
    logic                    emit;       // bottom-right pixel of the bin
    logic [COL_W-1:0]        col;        // bin column, line store address
    logic [ROW_W-1:0]        row;        // bin row
    logic                    last;       // last bin of the frame
  } ipb_op_t;

endpackage

>>> src/ipb_front.sv
// ----------------------------------------------------------------------------
// ipb_front
// Config registers, pixel decode and raster position tracking; classifies
// each pixel and pushes pixels that fall inside whole bins.
// ----------------------------------------------------------------------------
module ipb_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [2:0]                  cfg_idx_i,
  input  logic [ipb_pkg::DATA_W-1:0]  cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [31:0]                 pixel_word_i,
  input  logic                        full_i,
  output logic                        push_o,
  output ipb_pkg::ipb_op_t            op_o
);
  import ipb_pkg::*;

  // config registers
  logic [6:0]  bin_x_q, bin_y_q;
  logic [12:0] row_width_q, total_rows_q;
  ipb_fmt_e    fmt_q;

  // position counters
  logic [COL_W-1:0] pixel_col_q, pixel_col_d;
  logic [ROW_W-1:0] pixel_row_q, pixel_row_d;
  logic [5:0]       col_in_bin_q, col_in_bin_d;
  logic [5:0]       row_in_bin_q, row_in_bin_d;
  logic [COL_W-1:0] out_col_q, out_col_d;
  logic [ROW_W-1:0] out_row_q, out_row_d;
  logic [12:0]      col_start_q, col_start_d;   // first pixel column of current bin
  logic [12:0]      row_start_q, row_start_d;   // first pixel row of current bin row

  logic [6:0]  bx, by;
  logic [12:0] rw, tr;
  logic        in_col, in_row, in_bin, seg_end, row_done, row_end, frame_end;
  logic        last_col, last_row, accept;
  logic signed [PIX_W-1:0] pix;

  // clamped geometry
  always_comb begin
    bx = (bin_x_q == 7'd0) ? 7'd1 : ((bin_x_q > 7'(MAX_BIN)) ? 7'(MAX_BIN) : bin_x_q);
    by = (bin_y_q == 7'd0) ? 7'd1 : ((bin_y_q > 7'(MAX_BIN)) ? 7'(MAX_BIN) : bin_y_q);
    rw = (row_width_q == 13'd0) ? 13'd1 :
         ((row_width_q > 13'(MAX_ROW_WIDTH)) ? 13'(MAX_ROW_WIDTH) : row_width_q);
    tr = (total_rows_q == 13'd0) ? 13'd1 :
         ((total_rows_q > 13'(MAX_ROWS)) ? 13'(MAX_ROWS) : total_rows_q);
  end

  // pixel classification: a bin is whole if it ends inside the row / frame
  assign in_col    = ({1'b0, col_start_q} + {7'd0, bx}) <= {1'b0, rw};
  assign in_row    = ({1'b0, row_start_q} + {7'd0, by}) <= {1'b0, tr};
  assign last_col  = ({2'd0, col_start_q} + {8'd0, bx} + {8'd0, bx}) > {2'd0, rw};
  assign last_row  = ({2'd0, row_start_q} + {8'd0, by} + {8'd0, by}) > {2'd0, tr};
  assign in_bin    = in_col && in_row;
  assign seg_end   = {1'b0, col_in_bin_q} == (bx - 7'd1);
  assign row_done  = {1'b0, row_in_bin_q} == (by - 7'd1);
  assign row_end   = {1'b0, pixel_col_q} >= (rw - 13'd1);
  assign frame_end = {1'b0, pixel_row_q} >= (tr - 13'd1);

  // decode pixel word
  always_comb begin
    unique case (fmt_q)
      FMT_I32: pix = pixel_word_i;
      FMT_U16: pix = {16'd0, pixel_word_i[15:0]};
      FMT_I16: pix = {{16{pixel_word_i[15]}}, pixel_word_i[15:0]};
      FMT_U8:  pix = {24'd0, pixel_word_i[7:0]};
      default: pix = pixel_word_i;
    endcase
  end

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign push_o     = accept && in_bin;

  always_comb begin
    op_o.pix       = pix;
    op_o.seg_first = (col_in_bin_q == 6'd0);
    op_o.seg_end   = seg_end;
    op_o.row_first = (row_in_bin_q == 6'd0);
    op_o.emit      = seg_end && row_done;
    op_o.col       = out_col_q;
    op_o.row       = out_row_q;
    op_o.last      = last_col && last_row;
  end

  // position update per accepted word
  always_comb begin
    pixel_col_d  = pixel_col_q;
    pixel_row_d  = pixel_row_q;
    col_in_bin_d = col_in_bin_q;
    row_in_bin_d = row_in_bin_q;
    out_col_d    = out_col_q;
    out_row_d    = out_row_q;
    col_start_d  = col_start_q;
    row_start_d  = row_start_q;
    if (cfg_we_i) begin
      pixel_col_d  = '0;
      pixel_row_d  = '0;
      col_in_bin_d = '0;
      row_in_bin_d = '0;
      out_col_d    = '0;
      out_row_d    = '0;
      col_start_d  = '0;
      row_start_d  = '0;
    end else if (accept) begin
      if (in_bin) begin
        if (seg_end) begin
          col_in_bin_d = '0;
          out_col_d    = out_col_q + COL_W'(1);
          col_start_d  = {1'b0, pixel_col_q} + 13'd1;
        end else begin
          col_in_bin_d = col_in_bin_q + 6'd1;
        end
      end
      if (row_end) begin
        pixel_col_d  = '0;
        col_in_bin_d = '0;
        out_col_d    = '0;
        col_start_d  = '0;
        if (frame_end) begin
          pixel_row_d  = '0;
          row_in_bin_d = '0;
          out_row_d    = '0;
          row_start_d  = '0;
        end else begin
          pixel_row_d = pixel_row_q + ROW_W'(1);
          if (in_row) begin
            if (row_done) begin
              row_in_bin_d = '0;
              out_row_d    = out_row_q + ROW_W'(1);
              row_start_d  = {1'b0, pixel_row_q} + 13'd1;
            end else begin
              row_in_bin_d = row_in_bin_q + 6'd1;
            end
          end
        end
      end else begin
        pixel_col_d = pixel_col_q + COL_W'(1);
      end
    end
  end

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bin_x_q      <= 7'd2;
      bin_y_q      <= 7'd2;
      row_width_q  <= 13'(MAX_ROW_WIDTH);
      total_rows_q <= 13'(MAX_ROWS);
      fmt_q        <= FMT_I32;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_BIN_X:      bin_x_q      <= cfg_wdata_i[6:0];
        REG_BIN_Y:      bin_y_q      <= cfg_wdata_i[6:0];
        REG_ROW_WIDTH:  row_width_q  <= cfg_wdata_i;
        REG_TOTAL_ROWS: total_rows_q <= cfg_wdata_i;
        REG_FORMAT:     fmt_q        <= ipb_fmt_e'(cfg_wdata_i[1:0]);
        default: ;
      endcase
    end
  end

  // counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pixel_col_q  <= '0;
      pixel_row_q  <= '0;
      col_in_bin_q <= '0;
      row_in_bin_q <= '0;
      out_col_q    <= '0;
      out_row_q    <= '0;
      col_start_q  <= '0;
      row_start_q  <= '0;
    end else begin
      pixel_col_q  <= pixel_col_d;
      pixel_row_q  <= pixel_row_d;
      col_in_bin_q <= col_in_bin_d;
      row_in_bin_q <= row_in_bin_d;
      out_col_q    <= out_col_d;
      out_row_q    <= out_row_d;
      col_start_q  <= col_start_d;
      row_start_q  <= row_start_d;
    end
  end

endmodule

>>> src/ipb_fifo.sv
// ----------------------------------------------------------------------------
// ipb_fifo
// Four-entry queue of classified pixels between front and back.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ipb_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  ipb_pkg::ipb_op_t op_i,
  input  logic             pop_i,
  output ipb_pkg::ipb_op_t op_o,
  output logic             full_o,
  output logic             empty_o
);
  import ipb_pkg::*;

  ipb_op_t    mem_q [4];
  logic [1:0] wr_ptr_q, rd_ptr_q;
  logic [2:0] cnt_q;

  assign full_o  = (cnt_q == 3'd4);
  assign empty_o = (cnt_q == 3'd0);
  assign op_o    = mem_q[rd_ptr_q];

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + 2'd1;
      if (pop_i)  rd_ptr_q <= rd_ptr_q + 2'd1;
      cnt_q <= cnt_q + {2'd0, push_i} - {2'd0, pop_i};
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= op_i;
  end

  `ASSERT_NEVER(a_no_overflow, push_i && full_o, "push into full queue")
  `ASSERT_NEVER(a_no_underflow, pop_i && empty_o, "pop from empty queue")

endmodule

>>> src/ipb_back.sv
// ----------------------------------------------------------------------------
// ipb_back
// Sums pixels along each bin row segment, merges segments in the line
// store (read, add, write back), and holds the result word for output.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ipb_back (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  ipb_pkg::ipb_op_t                   op_i,
  input  logic                               empty_i,
  output logic                               pop_o,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [ipb_pkg::SUM_W-1:0]   bin_sum_o,
  output logic [ipb_pkg::COL_W-1:0]          bin_col_o,
  output logic [ipb_pkg::ROW_W-1:0]          bin_row_o,
  output logic                               frame_last_o
);
  import ipb_pkg::*;

  typedef struct packed {
    logic signed [SUM_W-1:0] seg;
    logic [COL_W-1:0]        idx;
    logic                    row_first;
    logic                    emit;
    logic [ROW_W-1:0]        row;
    logic                    last;
  } ipb_seg_t;

  // line store of partial column sums
  logic signed [SUM_W-1:0] line_mem [MAX_ROW_WIDTH];
  logic signed [SUM_W-1:0] rdata_q;

  logic signed [SUM_W-1:0] h_acc_q, seg;
  ipb_seg_t                s1_q;
  logic                    s1_vld_q, out_vld_q, fwd_hit_q;
  logic signed [SUM_W-1:0] fwd_q, base, sum;
  logic                    out_free, s1_adv, s1_ready, s1_load;

  // stage 0: horizontal segment accumulation
  assign seg = op_i.seg_first ? SUM_W'(op_i.pix) : (h_acc_q + SUM_W'(op_i.pix));

  assign out_free = !out_vld_q || out_ready_i;
  assign s1_adv   = s1_vld_q && (!s1_q.emit || out_free);
  assign s1_ready = !s1_vld_q || s1_adv;
  assign pop_o    = !empty_i && (!op_i.seg_end || s1_ready);
  assign s1_load  = pop_o && op_i.seg_end;

  // stage 1: merge with stored column sum, forward a same-cycle write
  assign base = fwd_hit_q ? fwd_q : rdata_q;
  assign sum  = s1_q.row_first ? s1_q.seg : (base + s1_q.seg);

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      fwd_hit_q <= 1'b0;
    end else begin
      if (s1_load) begin
        s1_vld_q  <= 1'b1;
        fwd_hit_q <= s1_adv && (s1_q.idx == op_i.col);
      end else if (s1_adv) begin
        s1_vld_q  <= 1'b0;
        fwd_hit_q <= 1'b0;
      end
      if (s1_adv && s1_q.emit) out_vld_q <= 1'b1;
      else if (out_ready_i)    out_vld_q <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (pop_o) h_acc_q <= seg;
    if (s1_load) begin
      s1_q.seg       <= seg;
      s1_q.idx       <= op_i.col;
      s1_q.row_first <= op_i.row_first;
      s1_q.emit      <= op_i.emit;
      s1_q.row       <= op_i.row;
      s1_q.last      <= op_i.last;
      fwd_q          <= sum;
    end
    if (s1_adv && s1_q.emit) begin
      bin_sum_o    <= sum;
      bin_col_o    <= s1_q.idx;
      bin_row_o    <= s1_q.row;
      frame_last_o <= s1_q.last;
    end
  end

  // line store ports: one write, one registered read
  always_ff @(posedge clk_i) begin
    if (s1_adv)  line_mem[s1_q.idx] <= sum;
    if (s1_load) rdata_q <= line_mem[op_i.col];
  end

  assign out_valid_o = out_vld_q;

  `ASSERT_CLK(a_s1_holds, s1_vld_q && !s1_adv |=> s1_vld_q, "segment lost while stalled")
  `ASSERT_CLK(a_fwd_needs_s1, fwd_hit_q |-> s1_vld_q, "forward flag without segment")
  `ASSERT_CLK(a_emit_shows, s1_adv && s1_q.emit |=> out_vld_q, "bin sum not presented")

endmodule

>>> src/image_pixel_binner_unit.sv
// ----------------------------------------------------------------------------
// image_pixel_binner_unit
// 2-D pixel binning: sums each bin_x by bin_y block of a raster frame.
//
//   channel   dir  handshake                  payload
//   cfg       in   cfg_we_i                   cfg_idx_i, cfg_wdata_i
//   pixel     in   in_valid_i / in_ready_o    pixel_word_i
//   bin       out  out_valid_o / out_ready_i  bin_sum_o, bin_col_o, bin_row_o,
//                                             frame_last_o
//
// One pixel word per cycle sustained while out_ready_i holds. A bin sum is valid once the
// last pixel of its bin has passed the queue write, segment stage, merge and output.
// Line store: 4096 x 44, one read and one write a cycle, same-column write forwarded.
// Reset clears config, counters and handshake state, not payload registers or the line store, whose
// entries a bin's first row always writes before they are read.
// A stalled output backs up through the four-word queue to in_ready_o.
// ----------------------------------------------------------------------------
module image_pixel_binner_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [2:0]                        cfg_idx_i,
  input  logic [ipb_pkg::DATA_W-1:0]        cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [31:0]                       pixel_word_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [ipb_pkg::SUM_W-1:0]  bin_sum_o,
  output logic [ipb_pkg::COL_W-1:0]         bin_col_o,
  output logic [ipb_pkg::ROW_W-1:0]         bin_row_o,
  output logic                              frame_last_o
);
  import ipb_pkg::*;

  ipb_op_t push_op, pop_op;
  logic    push, pop, full, empty;

  // front: config, decode, classification
  ipb_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .pixel_word_i (pixel_word_i),
    .full_i       (full),
    .push_o       (push),
    .op_o         (push_op)
  );

  // decoupling queue
  ipb_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .op_i    (push_op),
    .pop_i   (pop),
    .op_o    (pop_op),
    .full_o  (full),
    .empty_o (empty)
  );

  // back: accumulation and line store
  ipb_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .op_i         (pop_op),
    .empty_i      (empty),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .bin_sum_o    (bin_sum_o),
    .bin_col_o    (bin_col_o),
    .bin_row_o    (bin_row_o),
    .frame_last_o (frame_last_o)
  );

endmodule

>>> sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pixel binner testbench
// Streams raster frames into image_pixel_binner_unit and scores every bin
// sum it returns. A short directed table covers the pixel formats, the
// extreme words, register clamping, frame wrap and frame restarts on
// register writes. Randomly sized frames and two frames with the widest
// and the tallest bins follow. Expected bins come from a cycle-free model
// of the binning kept in this file, and the pixel and bin channels are
// paced under four idle patterns.
// ----------------------------------------------------------------------------
module testbench;
  import ipb_pkg::*;

  localparam int unsigned SETTLE_CYCLES = 12;       // pipeline + queue depth
  localparam int unsigned RANDOM_WORDS  = 1100;
  localparam int unsigned CYCLE_LIMIT   = 1000000;

  typedef struct packed {
    logic signed [SUM_W-1:0] sum;
    logic [COL_W-1:0]        col;
    logic [ROW_W-1:0]        row;
    logic                    last;
  } bin_t;

  typedef enum {ROW_REG, ROW_WORD} step_kind_e;
  typedef enum {OUT_MODEL, OUT_NONE, OUT_BIN} outcome_e;
  typedef enum {PACE_FULL, PACE_SEND_GAPS, PACE_RECV_STALLS, PACE_BOTH} pace_e;

  typedef struct {
    step_kind_e        kind;
    logic [2:0]        idx;
    logic [DATA_W-1:0] data;
    logic [31:0]       word;
    outcome_e          how;
    bin_t              bin;
  } script_row_t;

  // DUT ports
  logic                    clk_i        = 1'b0;
  logic                    rst_ni       = 1'b0;
  logic                    cfg_we_i     = 1'b0;
  logic [2:0]              cfg_idx_i    = REG_BIN_X;
  logic [DATA_W-1:0]       cfg_wdata_i  = '0;
  logic                    in_valid_i   = 1'b0;
  logic                    in_ready_o;
  logic [31:0]             pixel_word_i = '0;
  logic                    out_valid_o;
  logic                    out_ready_i  = 1'b0;
  logic signed [SUM_W-1:0] bin_sum_o;
  logic [COL_W-1:0]        bin_col_o;
  logic [ROW_W-1:0]        bin_row_o;
  logic                    frame_last_o;

  // Model registers and frame position
  int unsigned cf_bin_x, cf_bin_y, cf_row_width, cf_total_rows;
  ipb_fmt_e    cf_fmt;
  longint      line_sum [MAX_ROW_WIDTH];
  int unsigned px_col, px_row, row_in_bin, col_in_bin, bin_col_pos, bin_row_pos;

  bin_t        bins_pending[$];
  script_row_t script[$];
  pace_e       pace = PACE_FULL;
  int unsigned errors = 0;
  int unsigned bins_checked = 0;
  int unsigned words_binned = 0;
  int unsigned words_sent = 0;
  int unsigned settings_used = 0;
  int unsigned cycles = 0;

  image_pixel_binner_unit dut (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Model of the binning
  // --------------------------------------------------------------------------
  function automatic int unsigned clamp_to(int unsigned v, int unsigned hi);
    return (v < 1) ? 1 : ((v > hi) ? hi : v);
  endfunction

  function automatic longint decode_word(logic [31:0] w, ipb_fmt_e f);
    case (f)
      FMT_I32: return longint'($signed(w));
      FMT_U16: return longint'(w[15:0]);
      FMT_I16: return longint'($signed(w[15:0]));
      default: return longint'(w[7:0]);
    endcase
  endfunction

  function automatic void restart_position();
    px_col      = 0;
    px_row      = 0;
    row_in_bin  = 0;
    col_in_bin  = 0;
    bin_col_pos = 0;
    bin_row_pos = 0;
  endfunction

  function automatic void apply_reg(logic [2:0] idx, logic [DATA_W-1:0] d);
    case (idx)
      REG_BIN_X:      cf_bin_x      = d[6:0];
      REG_BIN_Y:      cf_bin_y      = d[6:0];
      REG_ROW_WIDTH:  cf_row_width  = d[12:0];
      REG_TOTAL_ROWS: cf_total_rows = d[12:0];
      REG_FORMAT:     cf_fmt        = ipb_fmt_e'(d[1:0]);
      default: ;
    endcase
    // any write, even to a spare index, starts a new frame
    restart_position();
  endfunction

  // Advance the model by one pixel word; got is set when a bin completes
  task automatic bin_word(input logic [31:0] w, output bit got, output bin_t res);
    int unsigned bx, by, rw, tr, nx, ny, used_w, used_h;
    longint      v;
    bit          in_rows;
    bx     = clamp_to(cf_bin_x, MAX_BIN);
    by     = clamp_to(cf_bin_y, MAX_BIN);
    rw     = clamp_to(cf_row_width, MAX_ROW_WIDTH);
    tr     = clamp_to(cf_total_rows, MAX_ROWS);
    nx     = rw / bx;
    ny     = tr / by;
    used_w = nx * bx;
    used_h = ny * by;
    v      = decode_word(w, cf_fmt);
    got    = 1'b0;
    res    = '0;

    // accumulate inside whole bins only
    if (px_col < used_w && px_row < used_h && bin_col_pos < MAX_ROW_WIDTH) begin
      words_binned++;
      if (row_in_bin == 0 && col_in_bin == 0) begin
        line_sum[bin_col_pos] = v;
      end else begin
        line_sum[bin_col_pos] += v;
      end
      if (row_in_bin == by - 1 && col_in_bin == bx - 1) begin
        got      = 1'b1;
        res.sum  = SUM_W'(line_sum[bin_col_pos]);
        res.col  = COL_W'(bin_col_pos);
        res.row  = ROW_W'(bin_row_pos);
        res.last = (bin_col_pos == nx - 1 && bin_row_pos == ny - 1);
      end
      if (col_in_bin == bx - 1) begin
        col_in_bin = 0;
        bin_col_pos++;
      end else begin
        col_in_bin++;
      end
    end

    // raster position, frame wrap
    if (px_col >= rw - 1) begin
      in_rows     = px_row < used_h;
      px_col      = 0;
      col_in_bin  = 0;
      bin_col_pos = 0;
      if (px_row >= tr - 1) begin
        restart_position();
      end else begin
        px_row++;
        if (in_rows) begin
          if (row_in_bin == by - 1) begin
            row_in_bin = 0;
            bin_row_pos++;
          end else begin
            row_in_bin++;
          end
        end
      end
    end else begin
      px_col++;
    end
  endtask

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------
  // One pixel word; valid is raised at a falling edge and held until taken
  task automatic push_pixel(input logic [31:0] w, input outcome_e how, input bin_t typed);
    int unsigned gap_pct;
    bit          got;
    bin_t        guess;
    gap_pct = (pace == PACE_SEND_GAPS) ? 58 : ((pace == PACE_BOTH) ? 8 : 0);
    @(negedge clk_i);
    while (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    pixel_word_i <= w;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    words_sent++;
    bin_word(w, got, guess);
    case (how)
      OUT_MODEL: if (got) bins_pending.push_back(guess);
      OUT_BIN:   bins_pending.push_back(typed);
      default: ;
    endcase
  endtask

  // Register write once the block has drained
  task automatic write_reg(input logic [2:0] idx, input logic [DATA_W-1:0] d);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (bins_pending.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= d;
    apply_reg(idx, d);
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic set_all_regs(input logic [DATA_W-1:0] bx, input logic [DATA_W-1:0] by,
                              input logic [DATA_W-1:0] rw, input logic [DATA_W-1:0] tr,
                              input logic [DATA_W-1:0] fmt);
    write_reg(REG_BIN_X, bx);
    write_reg(REG_BIN_Y, by);
    write_reg(REG_ROW_WIDTH, rw);
    write_reg(REG_TOTAL_ROWS, tr);
    write_reg(REG_FORMAT, fmt);
    settings_used++;
  endtask

  // Random pixel word, leaning on the format boundaries
  function automatic logic [31:0] rand_word();
    case ($urandom_range(11))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'hFFFF_FFFF;
      3: return {$urandom_range(65535), 16'h8000};
      4: return {$urandom_range(65535), 16'h7FFF};
      5: return {$urandom_range(16777215), 8'hFF};
      6: return '0;
      default: return $urandom();
    endcase
  endfunction

  // Directed table builders
  function automatic void add_reg(logic [2:0] idx, logic [DATA_W-1:0] d);
    script_row_t r;
    r.kind = ROW_REG; r.idx = idx; r.data = d; r.word = '0; r.how = OUT_NONE; r.bin = '0;
    script.push_back(r);
  endfunction

  function automatic void add_quiet(logic [31:0] w);
    script_row_t r;
    r.kind = ROW_WORD; r.idx = REG_BIN_X; r.data = '0; r.word = w; r.how = OUT_NONE;
    r.bin = '0;
    script.push_back(r);
  endfunction

  function automatic void add_bin(logic [31:0] w, longint sum, int col, int row, bit last);
    script_row_t r;
    r.kind     = ROW_WORD; r.idx = REG_BIN_X; r.data = '0; r.word = w; r.how = OUT_BIN;
    r.bin.sum  = SUM_W'(sum);
    r.bin.col  = COL_W'(col);
    r.bin.row  = ROW_W'(row);
    r.bin.last = last;
    script.push_back(r);
  endfunction

  // --------------------------------------------------------------------------
  // Bin channel: backpressure and scoring
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin
    int unsigned stall_pct;
    stall_pct = (pace == PACE_RECV_STALLS) ? 58 : ((pace == PACE_BOTH) ? 8 : 0);
    out_ready_i <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
  end

  task automatic check_field(input string what, input longint want, input longint seen);
    if (want != seen) begin
      errors++;
      if (errors <= 40)
        $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, what, want, seen);
    end
  endtask

  always @(posedge clk_i) begin
    bin_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (bins_pending.size() == 0) begin
        errors++;
        if (errors <= 40)
          $display("%0t ns: unexpected bin, expected none, got sum %0d col %0d row %0d",
                   $time, bin_sum_o, bin_col_o, bin_row_o);
      end else begin
        want = bins_pending.pop_front();
        bins_checked++;
        check_field("bin_sum", longint'($signed(want.sum)), longint'(bin_sum_o));
        check_field("bin_col", longint'(want.col), longint'(bin_col_o));
        check_field("bin_row", longint'(want.row), longint'(bin_row_o));
        check_field("frame_last", longint'(want.last), longint'(frame_last_o));
      end
    end
  end

  // Run watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t ns: timeout with %0d bins outstanding", $time, bins_pending.size());
      $display("[image_pixel_binner_unit] ERROR");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int unsigned directed_words, random_start, phase, bx, by, bxe, bye, rw, tr, fs, n, left;

    // reset defaults of the block
    cf_bin_x      = 2;
    cf_bin_y      = 2;
    cf_row_width  = 4096;
    cf_total_rows = 4096;
    cf_fmt        = FMT_I32;
    restart_position();

    // Directed table: default 2x2 bins first, then 1x1 bins so each word is its own sum
    add_quiet(32'hFFFF_FFFF);
    add_quiet(32'h0000_0001);
    add_reg(REG_BIN_X, 13'h1F80);               // zero after masking, clamps to 1
    add_reg(REG_BIN_Y, 13'd1);
    add_reg(REG_ROW_WIDTH, 13'd3);
    add_reg(REG_TOTAL_ROWS, 13'd2);
    add_reg(REG_FORMAT, DATA_W'(FMT_I32));
    add_bin(32'h8000_0000, -64'sd2147483648, 0, 0, 0);
    add_bin(32'h7FFF_FFFF, 64'sd2147483647, 1, 0, 0);
    add_bin(32'h0000_0000, 0, 2, 0, 0);
    add_bin(32'hFFFF_FFFF, -1, 0, 1, 0);
    add_reg(REG_FORMAT, DATA_W'(FMT_U16));
    add_bin(32'hFFFF_1234, 4660, 0, 0, 0);
    add_bin(32'h0000_FFFF, 65535, 1, 0, 0);
    add_reg(REG_FORMAT, DATA_W'(FMT_I16));
    add_bin(32'h1234_8000, -32768, 0, 0, 0);
    add_bin(32'hFFFF_7FFF, 32767, 1, 0, 0);
    add_reg(REG_FORMAT, 13'h1FFF);              // uint8, upper data bits ignored
    add_bin(32'hFFFF_FF80, 128, 0, 0, 0);
    add_bin(32'h1234_56FF, 255, 1, 0, 0);
    add_bin(32'h0000_0001, 1, 2, 0, 0);
    add_bin(32'h0000_007F, 127, 0, 1, 0);
    add_bin(32'h0000_00FE, 254, 1, 1, 0);
    add_bin(32'h0000_0003, 3, 2, 1, 1);         // last bin, frame wraps
    add_bin(32'h0000_0010, 16, 0, 0, 0);
    add_reg(REG_BIN_X, 13'd127);                // clamps to 64, wider than the row
    add_quiet(32'hAAAA_AAAA);
    add_quiet(32'h5555_5555);
    add_reg(REG_ROW_WIDTH, 13'd0);              // clamps to 1
    add_reg(REG_BIN_X, 13'd1);
    add_reg(REG_TOTAL_ROWS, 13'h1FFF);          // clamps to 4096
    add_bin(32'h0000_0005, 5, 0, 0, 0);
    add_bin(32'h0000_0006, 6, 0, 1, 0);
    add_reg(3'(REG_FORMAT + 3), 13'h0AAA);     // spare index still restarts the frame
    add_bin(32'h0000_0007, 7, 0, 0, 0);

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (script[i]) begin
      if (script[i].kind == ROW_REG) begin
        write_reg(script[i].idx, script[i].data);
        settings_used++;
      end else begin
        push_pixel(script[i].word, script[i].how, script[i].bin);
      end
    end
    directed_words = words_binned;

    // Random frames, mostly whole bins with skipped edges, some degenerate setups
    random_start = words_sent;
    phase = 0;
    while (words_sent - random_start < RANDOM_WORDS) begin
      pace = pace_e'(phase % 4);
      case ($urandom_range(19))
        0:       bx = 0;
        1:       bx = $urandom_range(65, 127);
        default: bx = $urandom_range(1, 6);
      endcase
      case ($urandom_range(19))
        0:       by = 0;
        1:       by = $urandom_range(65, 127);
        default: by = $urandom_range(1, 4);
      endcase
      bxe = clamp_to(bx, MAX_BIN);
      bye = clamp_to(by, MAX_BIN);
      if ($urandom_range(19) == 0)  rw = 0;
      else if (bxe > 8)             rw = $urandom_range(1, 24);
      else                          rw = bxe * $urandom_range(1, 4) + $urandom_range(0, 2);
      if ($urandom_range(19) == 0)  tr = 0;
      else if (bye > 8)             tr = $urandom_range(1, 16);
      else                          tr = bye * $urandom_range(1, 4) + $urandom_range(0, 2);
      set_all_regs({6'($urandom), 7'(bx)}, {6'($urandom), 7'(by)}, DATA_W'(rw),
                   DATA_W'(tr), {11'($urandom), 2'($urandom)});
      if ($urandom_range(4) == 0)
        write_reg(3'(REG_FORMAT + $urandom_range(1, 3)), DATA_W'($urandom));
      fs   = clamp_to(rw, MAX_ROW_WIDTH) * clamp_to(tr, MAX_ROWS);
      n    = fs * $urandom_range(1, 2) + $urandom_range(0, fs - 1);
      left = RANDOM_WORDS - (words_sent - random_start);
      if (n > left) n = left;
      repeat (n) push_pixel(rand_word(), OUT_MODEL, '0);
      phase++;
    end

    // Widest bin: one 64x4 bin of the most negative int32 pixel
    pace = PACE_RECV_STALLS;
    set_all_regs(13'd64, 13'd4, 13'd64, 13'd4, DATA_W'(FMT_I32));
    repeat (64 * 4) push_pixel(32'h8000_0000, OUT_MODEL, '0);

    // Tallest bin: one column of 64 rows of the largest int32 pixel
    pace = PACE_BOTH;
    set_all_regs(13'd1, 13'd64, 13'd1, 13'd64, DATA_W'(FMT_I32));
    repeat (64) push_pixel(32'h7FFF_FFFF, OUT_MODEL, '0);

    // Drain and let any trailing words clear the pipeline
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (bins_pending.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("%0d pixel words sent, %0d inside whole bins (%0d directed), %0d bins checked",
             words_sent, words_binned, directed_words, bins_checked);
    $display("%0d register settings over %0d random frame setups, four pacing patterns",
             settings_used, phase);
    if (errors == 0) begin
      $display("[image_pixel_binner_unit] OK");
    end else begin
      $display("[image_pixel_binner_unit] ERROR");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+src
src/ipb_pkg.sv
src/ipb_front.sv
src/ipb_fifo.sv
src/ipb_back.sv
src/image_pixel_binner_unit.sv
sim/testbench.sv
